// ----- rtl/dsb_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants of the delay-and-sum beamformer.
package dsb_pkg;

    localparam int MAX_SENSORS_DEF = 128;
    localparam int MAX_SAMPLES_DEF = 2048;
    localparam int COORD_BITS_DEF  = 20;

    localparam int CMD_W         = 2;
    localparam int SENSOR_IDX_W  = 7;
    localparam int SAMPLE_IDX_W  = 11;
    localparam int SAMPLE_W      = 16;
    localparam int POS_W         = 20;
    localparam int PIXEL_W       = 16;
    localparam int OOR_W         = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 24;
    localparam int NUM_SENSORS_W = 8;
    localparam int SPS_W         = 12;
    localparam int SPU_W         = 24;

    localparam logic [NUM_SENSORS_W-1:0] NUM_SENSORS_RST = 8'd128;
    localparam logic [SPS_W-1:0]         SPS_RST         = 12'd2048;
    localparam logic [SPU_W-1:0]         SPU_RST         = 24'd447392;

    typedef enum logic [CMD_W-1:0] {
        CMD_POS    = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_PIXEL  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_SENSORS        = 2'd0,
        REG_SAMPLES_PER_SENSOR = 2'd1,
        REG_SAMPLES_PER_UM     = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_START,
        ST_DIV,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

    // fraction bits kept on the distance
    function automatic int dist_frac(input int coord_bits);
        int f;
        f = (63 - 2 * coord_bits) / 2;
        return (f < 8) ? f : 8;
    endfunction

endpackage

// ----- rtl/dsb_geom.sv -----
`timescale 1ns / 1ps
// Sensor position store and squared pixel-to-sensor distance pipeline.
module dsb_geom #(
    parameter int MaxSensors = dsb_pkg::MAX_SENSORS_DEF,
    parameter int CoordBits  = dsb_pkg::COORD_BITS_DEF,
    localparam int KW  = (MaxSensors > 1) ? $clog2(MaxSensors) : 1,
    localparam int SqW = 2 * CoordBits + 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [KW-1:0]               wr_idx,
    input  logic signed [CoordBits-1:0] wr_x,
    input  logic signed [CoordBits-1:0] wr_z,
    input  dsb_pkg::tag_t               tag_in,
    input  logic [KW-1:0]               k_in,
    input  logic signed [CoordBits-1:0] px,
    input  logic signed [CoordBits-1:0] pz,
    output dsb_pkg::tag_t               tag_out,
    output logic [KW-1:0]               k_out,
    output logic [SqW-1:0]              d2
);
    import dsb_pkg::*;

    logic signed [CoordBits-1:0] x_mem [MaxSensors];
    logic signed [CoordBits-1:0] z_mem [MaxSensors];

    tag_t                        tag_a_reg, tag_b_reg, tag_c_reg, tag_d_reg;
    logic [KW-1:0]               k_a_reg, k_b_reg, k_c_reg, k_d_reg;
    logic signed [CoordBits-1:0] x_rd_reg, z_rd_reg;
    logic signed [CoordBits:0]   dx_reg, dz_reg;
    logic signed [SqW-1:0]       sqx_full, sqz_full;
    logic [SqW-2:0]              sqx_reg, sqz_reg;
    logic [SqW-1:0]              d2_reg;

    assign sqx_full = dx_reg * dx_reg;
    assign sqz_full = dz_reg * dz_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
            tag_d_reg <= '0;
        end
        else
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
            tag_d_reg <= tag_c_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (wr_en)
        begin
            x_mem[wr_idx] <= wr_x;
            z_mem[wr_idx] <= wr_z;
        end
        x_rd_reg <= x_mem[k_in];
        z_rd_reg <= z_mem[k_in];
        k_a_reg  <= k_in;
        dx_reg   <= (CoordBits+1)'(px) - (CoordBits+1)'(x_rd_reg);
        dz_reg   <= (CoordBits+1)'(pz) - (CoordBits+1)'(z_rd_reg);
        k_b_reg  <= k_a_reg;
        sqx_reg  <= sqx_full[SqW-2:0];
        sqz_reg  <= sqz_full[SqW-2:0];
        k_c_reg  <= k_b_reg;
        d2_reg   <= {1'b0, sqx_reg} + {1'b0, sqz_reg};
        k_d_reg  <= k_c_reg;
    end

    assign tag_out = tag_d_reg;
    assign k_out   = k_d_reg;
    assign d2      = d2_reg;

endmodule

// ----- rtl/dsb_sqrt.sv -----
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
module dsb_sqrt #(
    parameter int InW  = 42,
    parameter int Frac = 8,
    parameter int KeyW = 7,
    localparam int RootW = (InW + 2 * Frac + 1) / 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  dsb_pkg::tag_t   tag_in,
    input  logic [KeyW-1:0] k_in,
    input  logic [InW-1:0]  rad_in,
    output dsb_pkg::tag_t   tag_out,
    output logic [KeyW-1:0] k_out,
    output logic [RootW-1:0] root
);
    import dsb_pkg::*;

    localparam int RemW = RootW + 2;
    localparam int RadW = 2 * RootW;

    logic [RemW-1:0]  rem_reg  [RootW];
    logic [RootW-1:0] root_reg [RootW];
    logic [RadW-1:0]  rad_reg  [RootW];
    tag_t             tag_reg  [RootW];
    logic [KeyW-1:0]  k_reg    [RootW];

    for (genvar s = 0; s < RootW; s++) begin : g_stage
        logic [RemW-1:0]  rem_prev, cur, trial;
        logic [RootW-1:0] root_prev;
        logic [RadW-1:0]  rad_prev;
        tag_t             tag_prev;
        logic [KeyW-1:0]  k_prev;
        logic             fits;

        if (s == 0) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = RadW'(rad_in) << (2 * Frac);
            assign tag_prev  = tag_in;
            assign k_prev    = k_in;
        end
        else begin : g_next
            assign rem_prev  = rem_reg[s-1];
            assign root_prev = root_reg[s-1];
            assign rad_prev  = rad_reg[s-1];
            assign tag_prev  = tag_reg[s-1];
            assign k_prev    = k_reg[s-1];
        end

        // bring down the next two radicand bits and try root*4+1
        assign cur   = {rem_prev[RemW-3:0], rad_prev[RadW-1 -: 2]};
        assign trial = {root_prev, 2'b01};
        assign fits  = (cur >= trial);

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n)
            begin
                tag_reg[s] <= '0;
            end
            else
            begin
                tag_reg[s] <= tag_prev;
            end
        end

        always_ff @(posedge clk) begin
            rem_reg[s]  <= fits ? (cur - trial) : cur;
            root_reg[s] <= {root_prev[RootW-2:0], fits};
            rad_reg[s]  <= rad_prev << 2;
            k_reg[s]    <= k_prev;
        end
    end

    assign tag_out = tag_reg[RootW-1];
    assign k_out   = k_reg[RootW-1];
    assign root    = root_reg[RootW-1];

endmodule

// ----- rtl/dsb_delay.sv -----
`timescale 1ns / 1ps
// Distance to sample delay, range check and RF trace memory read.
module dsb_delay #(
    parameter int MaxSensors = dsb_pkg::MAX_SENSORS_DEF,
    parameter int MaxSamples = dsb_pkg::MAX_SAMPLES_DEF,
    parameter int RootW      = 29,
    parameter int Frac       = 8,
    localparam int KW   = (MaxSensors > 1) ? $clog2(MaxSensors) : 1,
    localparam int LenW = $clog2(MaxSamples + 1),
    localparam int AW   = $clog2(MaxSensors * MaxSamples)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [AW-1:0]                     wr_addr,
    input  logic signed [dsb_pkg::SAMPLE_W-1:0] wr_data,
    input  dsb_pkg::tag_t                     tag_in,
    input  logic [KW-1:0]                     k_in,
    input  logic [RootW-1:0]                  root_dist,
    input  logic [dsb_pkg::SPU_W-1:0]         spu,
    input  logic [LenW-1:0]                   len,
    output dsb_pkg::tag_t                     tag_out,
    output logic                              in_range,
    output logic signed [dsb_pkg::SAMPLE_W-1:0] sample
);
    import dsb_pkg::*;

    localparam int Depth = MaxSensors * MaxSamples;
    localparam int PW    = RootW + SPU_W;
    localparam int DW    = RootW + 1 - Frac;
    localparam int CmpW  = (DW > LenW) ? DW : LenW;
    localparam logic [PW:0] Half = (PW+1)'(1) << (Frac + 23);

    logic signed [SAMPLE_W-1:0] rf_mem [Depth];

    tag_t                   tag_1_reg, tag_2_reg, tag_3_reg, tag_4_reg;
    logic [KW-1:0]          k_1_reg, k_2_reg;
    logic [PW-1:0]          prod_reg;
    logic [PW:0]            rounded;
    logic [DW-1:0]          delay_reg;
    logic                   in_range_3_reg, in_range_4_reg;
    logic [AW-1:0]          addr_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;

    assign rounded = {1'b0, prod_reg} + Half;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            tag_1_reg <= '0;
            tag_2_reg <= '0;
            tag_3_reg <= '0;
            tag_4_reg <= '0;
        end
        else
        begin
            tag_1_reg <= tag_in;
            tag_2_reg <= tag_1_reg;
            tag_3_reg <= tag_2_reg;
            tag_4_reg <= tag_3_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (wr_en)
        begin
            rf_mem[wr_addr] <= wr_data;
        end
        prod_reg       <= PW'(root_dist) * PW'(spu);
        k_1_reg        <= k_in;
        delay_reg      <= rounded[PW -: DW];
        k_2_reg        <= k_1_reg;
        in_range_3_reg <= (delay_reg != '0) && (CmpW'(delay_reg) <= CmpW'(len));
        addr_reg       <= AW'(k_2_reg) * AW'(MaxSamples) + AW'(delay_reg - 1'b1);
        sample_reg     <= rf_mem[addr_reg];
        in_range_4_reg <= in_range_3_reg;
    end

    assign tag_out  = tag_4_reg;
    assign in_range = in_range_4_reg;
    assign sample   = sample_reg;

endmodule

// ----- rtl/dsb_div.sv -----
`timescale 1ns / 1ps
// Sequential signed divider, one quotient bit per cycle, truncating toward zero.
module dsb_div #(
    parameter int DivW = 24,
    parameter int DsrW = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [DivW-1:0] dividend,
    input  logic [DsrW-1:0]        divisor,
    output logic                   done,
    output logic signed [DivW-1:0] quotient
);
    localparam int CntW = $clog2(DivW + 1);

    logic            busy_reg, done_reg;
    logic [CntW-1:0] cnt_reg;
    logic [DsrW-1:0] rem_reg, dsr_reg;
    logic [DivW-1:0] quo_reg;
    logic            neg_reg;
    logic [DsrW:0]   shifted, diff;
    logic            ge;

    assign shifted = {rem_reg, quo_reg[DivW-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign ge      = (shifted >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CntW'(DivW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start)
        begin
            neg_reg <= dividend[DivW-1];
            quo_reg <= dividend[DivW-1] ? DivW'(-dividend) : DivW'(dividend);
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DsrW-1:0] : shifted[DsrW-1:0];
            quo_reg <= {quo_reg[DivW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -signed'(quo_reg) : signed'(quo_reg);

endmodule

// ----- rtl/delay_and_sum_beamformer.sv -----
`timescale 1ns / 1ps
// Delay-and-sum beamformer top level: command decode, sensor sequencing, sum and output.
// Load items (position or RF sample) give no result.
// A pixel is processed in order: one sensor issued per cycle, the geometry/sqrt/delay
// pipeline drains, then a one-bit-per-cycle divider runs over the sum.
// One pixel at a time.
// Reset restores the register defaults and idles the sequencer; stores are not cleared.
module delay_and_sum_beamformer #(
    parameter int MaxSensors = dsb_pkg::MAX_SENSORS_DEF,
    parameter int MaxSamples = dsb_pkg::MAX_SAMPLES_DEF,
    parameter int CoordBits  = dsb_pkg::COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input item channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [dsb_pkg::CMD_W-1:0]            cmd,
    input  logic [dsb_pkg::SENSOR_IDX_W-1:0]     sensor_index,
    input  logic [dsb_pkg::SAMPLE_IDX_W-1:0]     sample_index,
    input  logic signed [dsb_pkg::SAMPLE_W-1:0]  sample_value,
    input  logic signed [dsb_pkg::POS_W-1:0]     pos_x,
    input  logic signed [dsb_pkg::POS_W-1:0]     pos_z,
    // result item channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [dsb_pkg::PIXEL_W-1:0]   pixel_value,
    output logic [dsb_pkg::OOR_W-1:0]            out_of_range_count,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dsb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dsb_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import dsb_pkg::*;

    localparam int KW       = (MaxSensors > 1) ? $clog2(MaxSensors) : 1;
    localparam int NcW      = $clog2(MaxSensors + 1);
    localparam int NxW      = (NcW > NUM_SENSORS_W) ? NcW : NUM_SENSORS_W;
    localparam int LenW     = $clog2(MaxSamples + 1);
    localparam int LxW      = (LenW > SPS_W) ? LenW : SPS_W;
    localparam int DistFrac = dist_frac(CoordBits);
    localparam int SqW      = 2 * CoordBits + 2;
    localparam int RootW    = (SqW + 2 * DistFrac + 1) / 2;
    localparam int SumW     = SAMPLE_W + KW + 1;
    localparam int AW       = $clog2(MaxSensors * MaxSamples);

    // configuration registers
    logic [NUM_SENSORS_W-1:0] num_sensors_reg;
    logic [SPS_W-1:0]         sps_reg;
    logic [SPU_W-1:0]         spu_reg;

    // sequencer
    state_t                   state_reg, state_next;
    logic [KW-1:0]            k_reg;
    logic                     k_last;
    tag_t                     issue_tag;
    logic                     div_start, out_load;

    // pixel coordinates held for the whole sweep
    logic signed [CoordBits-1:0] px_reg, pz_reg;
    logic signed [CoordBits-1:0] in_x, in_z;

    // effective sensor count and trace length
    logic [NxW-1:0]  n_wide;
    logic [NcW-1:0]  n_eff;
    logic [LxW-1:0]  len_wide;
    logic [LenW-1:0] len_eff;

    // load decode
    logic            accept;
    logic            sensor_ok, sample_ok;
    logic            pos_wr_en, rf_wr_en;
    logic [AW-1:0]   rf_wr_addr;

    // pipeline links
    tag_t            geom_tag, sqrt_tag, dl_tag;
    logic [KW-1:0]   geom_k, sqrt_k;
    logic [SqW-1:0]  d2;
    logic [RootW-1:0] root_dist;
    logic            dl_in_range;
    logic signed [SAMPLE_W-1:0] dl_sample;

    // accumulation and result
    logic signed [SumW-1:0] sum_reg;
    logic [OOR_W-1:0]       bad_reg;
    logic                   div_done;
    logic signed [SumW-1:0] quotient;
    logic                   out_valid_reg;
    logic [PIXEL_W-1:0]     pixel_reg;
    logic [OOR_W-1:0]       oor_reg;

    assign cfg_ready = 1'b1;

    // a zero count acts as one sensor; counts above the store saturate
    assign n_wide = (num_sensors_reg == '0) ? NxW'(1) : NxW'(num_sensors_reg);
    assign n_eff  = (n_wide > NxW'(MaxSensors)) ? NcW'(MaxSensors) : NcW'(n_wide);

    assign len_wide = LxW'(sps_reg);
    assign len_eff  = (len_wide > LxW'(MaxSamples)) ? LenW'(MaxSamples) : LenW'(len_wide);

    // coordinates wrap to the configured width
    assign in_x = CoordBits'(pos_x);
    assign in_z = CoordBits'(pos_z);

    assign accept     = in_valid && in_ready;
    assign sensor_ok  = (int'(sensor_index) < MaxSensors);
    assign sample_ok  = (int'(sample_index) < MaxSamples);
    assign pos_wr_en  = accept && (cmd == CMD_POS) && sensor_ok;
    assign rf_wr_en   = accept && (cmd == CMD_SAMPLE) && sensor_ok && sample_ok;
    assign rf_wr_addr = AW'(sensor_index) * AW'(MaxSamples) + AW'(sample_index);

    assign k_last = (NcW'(k_reg) == NcW'(n_eff - 1'b1));

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            num_sensors_reg <= NUM_SENSORS_RST;
            sps_reg         <= SPS_RST;
            spu_reg         <= SPU_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_NUM_SENSORS:        num_sensors_reg <= cfg_data[NUM_SENSORS_W-1:0];
                REG_SAMPLES_PER_SENSOR: sps_reg         <= cfg_data[SPS_W-1:0];
                REG_SAMPLES_PER_UM:     spu_reg         <= cfg_data[SPU_W-1:0];
                default:                ;
            endcase
        end
    end

    // sequencer: issue one sensor per cycle, wait for the last one, divide, hand off
    always_comb begin
        state_next = state_reg;
        in_ready   = 1'b0;
        issue_tag  = '0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && (cmd == CMD_PIXEL))
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                issue_tag.valid = 1'b1;
                issue_tag.last  = k_last;
                if (k_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (dl_tag.valid && dl_tag.last)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                // hold the quotient until the output register frees up
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            sum_reg       <= '0;
            bad_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept && (cmd == CMD_PIXEL))
            begin
                k_reg   <= '0;
                sum_reg <= '0;
                bad_reg <= '0;
            end
            else
            begin
                if (state_reg == ST_ISSUE)
                begin
                    k_reg <= k_reg + 1'b1;
                end
                // accumulate; an out-of-range sensor adds zero and is counted
                if (dl_tag.valid)
                begin
                    if (dl_in_range)
                    begin
                        sum_reg <= sum_reg + SumW'(dl_sample);
                    end
                    else if (bad_reg != '1)
                    begin
                        bad_reg <= bad_reg + 1'b1;
                    end
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (accept && (cmd == CMD_PIXEL))
        begin
            px_reg <= in_x;
            pz_reg <= in_z;
        end
        if (out_load)
        begin
            pixel_reg <= quotient[PIXEL_W-1:0];
            oor_reg   <= bad_reg;
        end
    end

    dsb_geom #(
        .MaxSensors (MaxSensors),
        .CoordBits  (CoordBits)
    ) u_geom (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (pos_wr_en),
        .wr_idx  (KW'(sensor_index)),
        .wr_x    (in_x),
        .wr_z    (in_z),
        .tag_in  (issue_tag),
        .k_in    (k_reg),
        .px      (px_reg),
        .pz      (pz_reg),
        .tag_out (geom_tag),
        .k_out   (geom_k),
        .d2      (d2)
    );

    dsb_sqrt #(
        .InW  (SqW),
        .Frac (DistFrac),
        .KeyW (KW)
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (geom_tag),
        .k_in    (geom_k),
        .rad_in  (d2),
        .tag_out (sqrt_tag),
        .k_out   (sqrt_k),
        .root    (root_dist)
    );

    dsb_delay #(
        .MaxSensors (MaxSensors),
        .MaxSamples (MaxSamples),
        .RootW      (RootW),
        .Frac       (DistFrac)
    ) u_delay (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (rf_wr_en),
        .wr_addr   (rf_wr_addr),
        .wr_data   (sample_value),
        .tag_in    (sqrt_tag),
        .k_in      (sqrt_k),
        .root_dist (root_dist),
        .spu       (spu_reg),
        .len       (len_eff),
        .tag_out   (dl_tag),
        .in_range  (dl_in_range),
        .sample    (dl_sample)
    );

    dsb_div #(
        .DivW (SumW),
        .DsrW (NcW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (n_eff),
        .done     (div_done),
        .quotient (quotient)
    );

    assign out_valid          = out_valid_reg;
    assign pixel_value        = pixel_reg;
    assign out_of_range_count = oor_reg;

endmodule
